// ----- rtl/three_tap_modulated_chorus_macros.svh -----
// Assertion macros for the three-tap chorus checker.
// Needs clk_i and rst_ni in the scope of use.
`ifndef THREE_TAP_MODULATED_CHORUS_MACROS_SVH
`define THREE_TAP_MODULATED_CHORUS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ttmc_pkg.sv -----
// Shared types, constants and sine table functions for the three-tap chorus.
// No dependencies.
package ttmc_pkg;

  localparam int DelayBits   = 25;
  localparam int DepthBits   = 24;
  localparam int PeriodBits  = 20;
  localparam int PhaseBits   = 32;
  localparam int StepBits    = 24;
  localparam int OutBits     = 18;
  localparam int FracBits    = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;
  localparam int SmoothCoef  = 66;

  localparam logic [DelayBits-1:0]  DelayMax       = 25'h1FFFFFF;
  localparam logic [DelayBits-1:0]  BaseDelayReset = 25'd7208960;
  localparam logic [DepthBits-1:0]  DepthReset     = 24'd2621440;
  localparam logic [PeriodBits-1:0] PeriodReset    = 20'd40000;
  localparam logic [PhaseBits-1:0]  PhaseStepReset = 32'd107374;
  localparam logic [StepBits-1:0]   LfoStepReset   = 24'd131;

  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint TwoPiQ30  = 64'sd6746518852;

  typedef enum logic [1:0] {
    LFO_SQUARE   = 2'd0,
    LFO_TRIANGLE = 2'd1,
    LFO_RAMP     = 2'd2,
    LFO_SINE     = 2'd3
  } lfo_mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LFO_MODE   = 3'd0,
    CFG_BASE_DELAY = 3'd1,
    CFG_LFO_DEPTH  = 3'd2,
    CFG_PERIOD     = 3'd3,
    CFG_PHASE_STEP = 3'd4,
    CFG_LFO_STEP   = 3'd5
  } cfg_index_e;

  // sin(a), a in [0, pi/2], Q30 in and out
  function automatic longint sin_q30(longint a);
    longint x2;
    longint term;
    longint sum;
    x2   = (a * a) >>> 30;
    term = a;
    sum  = a;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    return sum;
  endfunction

  // Q15 sine entry for an angle in [0, 2*pi), Q30
  function automatic logic signed [15:0] sine_entry(longint angle);
    longint a;
    longint s;
    longint q;
    logic   neg;
    a   = angle;
    neg = 1'b0;
    if (a >= PiQ30) begin
      a   = a - PiQ30;
      neg = 1'b1;
    end
    if (a > HalfPiQ30) begin
      a = PiQ30 - a;
    end
    s = sin_q30(a);
    if (s < 0) begin
      s = 0;
    end
    q = (s + 64'sd16384) >>> 15;
    if (q > 32767) begin
      q = 32767;
    end
    if (neg) begin
      q = -q;
    end
    return 16'(q);
  endfunction

endpackage

// ----- rtl/three_tap_modulated_chorus.sv -----
// Three-tap modulated chorus: one delay store, an LFO and a shared multiplier.
// Depends on ttmc_pkg.
//
// A sample is accepted in S_IDLE, then passes through S_LFO, S_LMUL, S_LFIN,
// S_TAPA to S_TAPD once per tap and S_OUT, which waits while the output
// transaction stalls. No new sample is taken before the last is through, as
// the multiplier and the read port of the delay store are single and shared.
// The store is not cleared after reset; a fill count makes entries never
// written read as zero, so the block is ready right after reset.
module three_tap_modulated_chorus
  import ttmc_pkg::*;
#(
  parameter int DELAY_DEPTH     = 512,
  parameter int TAP_SPACING     = 50,
  parameter int SAMPLE_BITS     = 16,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxBits-1:0]         cfg_index_i,
  input  logic [CfgDataBits-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [OutBits-1:0]     sample_out_o
);

  localparam int AddrBits = $clog2(DELAY_DEPTH);
  localparam int IdxBits  = $clog2(SINE_TABLE_SIZE);
  localparam int ScaleW   = PhaseBits + IdxBits + 1;
  localparam int SumW     = SAMPLE_BITS + 2;
  localparam int WideW    = 27;
  localparam int MulAW    = 26;
  localparam int MulBW    = 18;
  localparam int ProdW    = MulAW + MulBW;
  localparam logic [WideW-1:0] TapOff1 = WideW'(TAP_SPACING) << FracBits;
  localparam logic [WideW-1:0] TapOff2 = WideW'(2 * TAP_SPACING) << FracBits;
  localparam logic [WideW-1:0] TapMax  =
    (WideW'(DELAY_DEPTH - 2) << FracBits) | WideW'(17'h0FFFF);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LFO  = 9'b000000010,
    S_LMUL = 9'b000000100,
    S_LFIN = 9'b000001000,
    S_TAPA = 9'b000010000,
    S_TAPB = 9'b000100000,
    S_TAPC = 9'b001000000,
    S_TAPD = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e                    state_q, state_d;
  lfo_mode_e                 mode_q, mode_d;
  logic [DelayBits-1:0]      base_q, base_d;
  logic [DepthBits-1:0]      depth_q, depth_d;
  logic [PeriodBits-1:0]     period_q, period_d;
  logic [PhaseBits-1:0]      pstep_q, pstep_d;
  logic [StepBits-1:0]       lstep_q, lstep_d;
  logic [DelayBits-1:0]      delay_q, delay_d;
  logic [DelayBits-1:0]      target_q, target_d;
  logic                      falling_q, falling_d;
  logic [PeriodBits-1:0]     tick_q, tick_d;
  logic [PhaseBits-1:0]      phase_q, phase_d;
  logic [AddrBits-1:0]       wr_q, wr_d;
  logic [AddrBits:0]         fill_q, fill_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic signed [15:0]        sine_q, sine_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [ProdW-1:0]   acc_q, acc_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic [1:0]                tap_q, tap_d;
  logic [FracBits-1:0]       frac_q, frac_d;
  logic [AddrBits-1:0]       i0_q, i0_d;
  logic                      ok0_q, ok0_d, ok1_q, ok1_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [OutBits-1:0] out_q, out_d;

  logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic [AddrBits-1:0]           rd_addr;
  logic                          mem_we;

  logic signed [15:0]        sine_rom [SINE_TABLE_SIZE];
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   mul_p;

  logic [DelayBits-1:0]      lo_val, hi_val;
  logic [DelayBits:0]        hi_sum;
  logic signed [WideW-1:0]   tri_nd, ramp_nd, fin_nd;
  logic [DelayBits-1:0]      tri_cl, ramp_cl;
  logic [ScaleW-1:0]         phase_scaled;
  logic [WideW-1:0]          tap_t, tap_c;
  logic [AddrBits-1:0]       tap_dl;
  logic [AddrBits:0]         wr_ext;
  logic [AddrBits-1:0]       i0_val, i1_val;
  logic signed [SAMPLE_BITS-1:0] x_rd;
  logic signed [ProdW-1:0]   tap_shift;
  logic signed [WideW-1:0]   sum_wide;
  logic                      tick_clr;

  for (genvar gi = 0; gi < SINE_TABLE_SIZE; gi++) begin : g_sine
    localparam longint Angle = (TwoPiQ30 * gi) / SINE_TABLE_SIZE;
    assign sine_rom[gi] = sine_entry(Angle);
  end

  function automatic logic [DelayBits-1:0] clamp_d(logic signed [WideW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({2'b00, DelayMax})) begin
      return DelayMax;
    end
    return v[DelayBits-1:0];
  endfunction

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  assign lo_val  = (base_q >= DelayBits'(depth_q)) ? base_q - DelayBits'(depth_q) : '0;
  assign hi_sum  = {1'b0, base_q} + {2'b00, depth_q};
  assign hi_val  = hi_sum[DelayBits] ? DelayMax : hi_sum[DelayBits-1:0];
  assign tri_nd  = falling_q ?
                   $signed({2'b00, delay_q}) - $signed({2'b00, lstep_q, 1'b0}) :
                   $signed({2'b00, delay_q}) + $signed({2'b00, lstep_q, 1'b0});
  assign tri_cl  = clamp_d(tri_nd);
  assign ramp_nd = $signed({2'b00, target_q}) + $signed({3'b000, lstep_q});
  assign ramp_cl = clamp_d(ramp_nd);
  assign fin_nd  = (mode_q == LFO_SINE) ?
                   $signed({2'b00, base_q}) + WideW'(prod_q >>> 15) :
                   $signed({2'b00, delay_q}) + WideW'(prod_q >>> FracBits);
  assign phase_scaled = ScaleW'(phase_q) * ScaleW'(SINE_TABLE_SIZE);

  always_comb begin
    case (tap_q)
      2'd1:    tap_t = {2'b00, delay_q} + TapOff1;
      2'd2:    tap_t = {2'b00, delay_q} + TapOff2;
      default: tap_t = {2'b00, delay_q};
    endcase
  end
  assign tap_c  = (tap_t > TapMax) ? TapMax : tap_t;
  assign tap_dl = tap_c[FracBits +: AddrBits];
  assign wr_ext = {1'b0, wr_q};
  assign i0_val = (wr_q >= tap_dl) ? wr_q - tap_dl :
                  AddrBits'(wr_ext + (AddrBits + 1)'(DELAY_DEPTH) - {1'b0, tap_dl});
  assign i1_val = (i0_q == '0) ? AddrBits'(DELAY_DEPTH - 1) : i0_q - 1'b1;
  assign x_rd   = (state_q == S_TAPB) ? (ok0_q ? rd_q : '0) : (ok1_q ? rd_q : '0);
  assign tap_shift = acc_q >>> FracBits;
  assign sum_wide  = WideW'(sum_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    base_d      = base_q;
    depth_d     = depth_q;
    period_d    = period_q;
    pstep_d     = pstep_q;
    lstep_d     = lstep_q;
    delay_d     = delay_q;
    target_d    = target_q;
    falling_d   = falling_q;
    tick_d      = tick_q;
    phase_d     = phase_q;
    wr_d        = wr_q;
    fill_d      = fill_q;
    x_d         = x_q;
    sine_d      = sine_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    tap_d       = tap_q;
    frac_d      = frac_q;
    i0_d        = i0_q;
    ok0_d       = ok0_q;
    ok1_d       = ok1_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    rd_addr     = i0_val;
    mul_a       = '0;
    mul_b       = '0;
    tick_clr    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mem_we  = 1'b1;
          x_d     = sample_in_i;
          fill_d  = (fill_q == (AddrBits + 1)'(DELAY_DEPTH)) ? fill_q : fill_q + 1'b1;
          state_d = S_LFO;
        end
      end
      S_LFO: begin
        case (mode_q)
          LFO_SQUARE: begin
            if (tick_q >= (period_q >> 1)) begin
              target_d = (target_q == lo_val) ? hi_val : lo_val;
              tick_clr = 1'b1;
            end
          end
          LFO_TRIANGLE: begin
            delay_d = tri_cl;
            if (tri_cl >= hi_val || tri_cl <= lo_val) begin
              falling_d = ~falling_q;
              tick_clr  = 1'b1;
            end
          end
          LFO_RAMP: begin
            if (ramp_cl >= hi_val) begin
              target_d = lo_val;
              tick_clr = 1'b1;
            end else begin
              target_d = ramp_cl;
            end
          end
          default: begin
            sine_d  = sine_rom[phase_scaled[PhaseBits +: IdxBits]];
            phase_d = phase_q + pstep_q;
            tick_clr = (tick_q == period_q);
          end
        endcase
        tick_d  = (tick_clr ? '0 : tick_q) + 1'b1;
        state_d = S_LMUL;
      end
      S_LMUL: begin
        if (mode_q == LFO_SINE) begin
          mul_a = $signed({2'b00, depth_q});
          mul_b = MulBW'(sine_q);
        end else begin
          mul_a = MulAW'($signed({2'b00, target_q}) - $signed({2'b00, delay_q}));
          mul_b = MulBW'(SmoothCoef);
        end
        prod_d  = mul_p;
        state_d = S_LFIN;
      end
      S_LFIN: begin
        if (mode_q != LFO_TRIANGLE) begin
          delay_d = clamp_d(fin_nd);
        end
        sum_d   = SumW'(x_q);
        tap_d   = '0;
        state_d = S_TAPA;
      end
      S_TAPA: begin
        rd_addr = i0_val;
        i0_d    = i0_val;
        frac_d  = tap_c[FracBits-1:0];
        ok0_d   = {1'b0, tap_dl} < fill_q;
        ok1_d   = ({1'b0, tap_dl} + 1'b1) < fill_q;
        state_d = S_TAPB;
      end
      S_TAPB: begin
        rd_addr = i1_val;
        mul_a   = MulAW'(x_rd);
        mul_b   = MulBW'(18'sh10000 - $signed({2'b00, frac_q}));
        prod_d  = mul_p;
        state_d = S_TAPC;
      end
      S_TAPC: begin
        mul_a   = MulAW'(x_rd);
        mul_b   = $signed({2'b00, frac_q});
        acc_d   = prod_q + mul_p;
        state_d = S_TAPD;
      end
      S_TAPD: begin
        sum_d = sum_q + SumW'(tap_shift);
        if (tap_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          tap_d   = tap_q + 1'b1;
          state_d = S_TAPA;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = sum_wide[OutBits-1:0];
          out_valid_d = 1'b1;
          wr_d        = (wr_q == AddrBits'(DELAY_DEPTH - 1)) ? '0 : wr_q + 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LFO_MODE:   mode_d = lfo_mode_e'(cfg_data_i[1:0]);
        CFG_BASE_DELAY: begin
          base_d  = cfg_data_i[DelayBits-1:0];
          delay_d = cfg_data_i[DelayBits-1:0];
        end
        CFG_LFO_DEPTH: begin
          depth_d = cfg_data_i[DepthBits-1:0];
          delay_d = base_q;
        end
        CFG_PERIOD: begin
          period_d = cfg_data_i[PeriodBits-1:0];
          delay_d  = base_q;
        end
        CFG_PHASE_STEP: pstep_d = cfg_data_i;
        CFG_LFO_STEP:   lstep_d = cfg_data_i[StepBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_q] <= sample_in_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= LFO_SINE;
      base_q      <= BaseDelayReset;
      depth_q     <= DepthReset;
      period_q    <= PeriodReset;
      pstep_q     <= PhaseStepReset;
      lstep_q     <= LfoStepReset;
      delay_q     <= BaseDelayReset;
      target_q    <= '0;
      falling_q   <= 1'b0;
      tick_q      <= '0;
      phase_q     <= '0;
      wr_q        <= '0;
      fill_q      <= '0;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      base_q      <= base_d;
      depth_q     <= depth_d;
      period_q    <= period_d;
      pstep_q     <= pstep_d;
      lstep_q     <= lstep_d;
      delay_q     <= delay_d;
      target_q    <= target_d;
      falling_q   <= falling_d;
      tick_q      <= tick_d;
      phase_q     <= phase_d;
      wr_q        <= wr_d;
      fill_q      <= fill_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    sine_q <= sine_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
    frac_q <= frac_d;
    i0_q   <= i0_d;
    ok0_q  <= ok0_d;
    ok1_q  <= ok1_d;
    out_q  <= out_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

// ----- rtl/ttmc_checker.sv -----
// Port-level checker for the three-tap chorus, bound to the top level.
// Depends on ttmc_pkg and three_tap_modulated_chorus_macros.svh.
`include "three_tap_modulated_chorus_macros.svh"

module ttmc_checker
  import ttmc_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [OutBits-1:0] sample_out_o
);

  `TTMC_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "ready after transaction")
  `TTMC_ASSERT_SAME(a_out_ends_work, $rose(out_valid_o), in_ready_o && $past(!in_ready_o), "result outside work")
  `TTMC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "valid dropped")
  `TTMC_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(sample_out_o), "payload changed")

endmodule

bind three_tap_modulated_chorus ttmc_checker u_ttmc_checker (.*);
